@@ rtl/spmv_pkg.sv @@
// ============================================================================
// spmv_pkg
// Shared types and constants for the CSR sparse matrix-vector multiply unit.
// ============================================================================
package spmv_pkg;

   localparam int X_DEPTH_DEFAULT   = 4096;
   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int COLUMN_WIDTH = 12;
   localparam int ROW_WIDTH    = 16;
   localparam int VALUE_WIDTH  = 32;
   localparam int PROD_WIDTH   = 2 * VALUE_WIDTH;

   // result queue depth: covers the two pipeline stages, the word being accepted and a waiting word
   localparam int RSP_FIFO_DEPTH = 4;

   localparam logic signed [PROD_WIDTH-1:0] SUM_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [PROD_WIDTH-1:0] SUM_MIN = 64'shFFFF_FFFF_8000_0000;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BEGIN = 2'd1,
      OP_TERM  = 2'd2
   } spmv_op_type;

   typedef struct packed {
      logic [1:0]                     op;
      logic [COLUMN_WIDTH-1:0]        column;
      logic [ROW_WIDTH-1:0]           row_index;
      logic signed [VALUE_WIDTH-1:0]  value;
      logic                           last_entry;
      logic                           empty_row;
   } spmv_req_type;

   typedef struct packed {
      logic [ROW_WIDTH-1:0]           out_row;
      logic signed [VALUE_WIDTH-1:0]  y_value;
      logic                           saturated;
   } spmv_rsp_type;

   // occupancy of the datapath pipeline, reported to flow control
   typedef struct packed {
      logic s1_busy;
      logic s2_busy;
   } spmv_pipe_status_type;

endpackage

@@ rtl/spmv_datapath.sv @@
// ============================================================================
// spmv_datapath
// x store, multiplier and saturating row accumulator, three stages deep.
// ============================================================================
module spmv_datapath
   import spmv_pkg::*;
#(
   parameter int X_DEPTH   = X_DEPTH_DEFAULT,
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_accept,
   input  spmv_req_type         req_word,
   output logic                 push_valid,
   output spmv_rsp_type         push_word,
   output spmv_pipe_status_type status
);

   localparam int AW = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;
   // one bit above both the column and the address, so X_DEPTH itself fits
   localparam int WW = ((AW > COLUMN_WIDTH) ? AW : COLUMN_WIDTH) + 1;

   logic [VALUE_WIDTH-1:0] x_mem [X_DEPTH];

   logic [WW-1:0] col_wide;
   logic [AW-1:0] addr;
   logic          in_range;

   assign col_wide = WW'(req_word.column);
   assign addr     = col_wide[AW-1:0];
   assign in_range = (col_wide < WW'(X_DEPTH));

   // stage 1: memory read
   logic                   s1_valid_ff;
   spmv_req_type           s1_word_ff;
   logic                   s1_in_range_ff;
   logic [VALUE_WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req_accept && in_range && (req_word.op == OP_LOAD)) begin
         x_mem[addr] <= req_word.value;
      end
      if (req_accept && in_range && (req_word.op == OP_TERM)) begin
         rdata_ff <= x_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
      s1_word_ff     <= req_word;
      s1_in_range_ff <= in_range;
   end

   // stage 2: multiply
   logic signed [VALUE_WIDTH-1:0] x_val;
   logic signed [PROD_WIDTH-1:0]  prod_in;
   logic signed [PROD_WIDTH-1:0]  prod_ff;
   logic                          s2_valid_ff;
   spmv_req_type                  s2_word_ff;

   assign x_val   = s1_in_range_ff ? $signed(rdata_ff) : '0;
   assign prod_in = PROD_WIDTH'(x_val) * PROD_WIDTH'(s1_word_ff.value);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_word_ff <= s1_word_ff;
      prod_ff    <= prod_in;
   end

   // stage 3: accumulate and clamp
   logic signed [VALUE_WIDTH-1:0] sum_ff, sum_in;
   logic [ROW_WIDTH-1:0]          row_ff, row_in;
   logic                          clip_ff, clip_in;
   logic signed [PROD_WIDTH-1:0]  shifted;
   logic signed [PROD_WIDTH-1:0]  sum_wide;
   logic signed [VALUE_WIDTH-1:0] clamped;
   logic                          clamp_hit;

   assign shifted  = prod_ff >>> FRAC_BITS;
   assign sum_wide = PROD_WIDTH'(sum_ff) + shifted;

   always_comb begin
      if (sum_wide > SUM_MAX) begin
         clamped   = SUM_MAX[VALUE_WIDTH-1:0];
         clamp_hit = 1'b1;
      end else if (sum_wide < SUM_MIN) begin
         clamped   = SUM_MIN[VALUE_WIDTH-1:0];
         clamp_hit = 1'b1;
      end else begin
         clamped   = sum_wide[VALUE_WIDTH-1:0];
         clamp_hit = 1'b0;
      end
   end

   always_comb begin
      sum_in     = sum_ff;
      row_in     = row_ff;
      clip_in    = clip_ff;
      push_valid = 1'b0;
      push_word  = '{out_row: row_ff, y_value: clamped, saturated: clip_ff};
      if (s2_valid_ff) begin
         case (s2_word_ff.op)
            OP_BEGIN: begin
               sum_in     = s2_word_ff.value;
               row_in     = s2_word_ff.row_index;
               clip_in    = 1'b0;
               push_valid = s2_word_ff.empty_row;
               push_word  = '{out_row: s2_word_ff.row_index,
                              y_value: s2_word_ff.value, saturated: 1'b0};
            end
            OP_TERM: begin
               sum_in     = clamped;
               clip_in    = clip_ff | clamp_hit;
               push_valid = s2_word_ff.last_entry;
               push_word  = '{out_row: row_ff, y_value: clamped,
                              saturated: clip_ff | clamp_hit};
            end
            default: begin
               // loads and the unused code leave the row state alone
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         row_ff  <= '0;
         clip_ff <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         row_ff  <= row_in;
         clip_ff <= clip_in;
      end
   end

   assign status = '{s1_busy: s1_valid_ff, s2_busy: s2_valid_ff};

endmodule

@@ rtl/spmv_rsp_fifo.sv @@
// ============================================================================
// spmv_rsp_fifo
// Small result queue that decouples the datapath from the result channel.
// ============================================================================
module spmv_rsp_fifo
   import spmv_pkg::*;
(
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push_valid,
   input  spmv_rsp_type                           push_word,
   input  logic                                   pop,
   output logic [$clog2(RSP_FIFO_DEPTH+1)-1:0]    count,
   output logic                                   out_valid,
   output spmv_rsp_type                           out_word
);

   localparam int PW = $clog2(RSP_FIFO_DEPTH);
   localparam int CW = $clog2(RSP_FIFO_DEPTH + 1);

   spmv_rsp_type  entries_ff [RSP_FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PW'(RSP_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(RSP_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign count     = count_ff;
   assign out_valid = (count_ff != '0);
   assign out_word  = entries_ff[rd_ptr_ff];

endmodule

@@ rtl/csr_sparse_matrix_vector_multiply_unit.sv @@
// ============================================================================
// csr_sparse_matrix_vector_multiply_unit
// Row-by-row y = seed + A*x for a matrix streamed in CSR order, Q16.16.
// ============================================================================
//
//  channel  direction  handshake            word
//  -------  ---------  -------------------  -------------------------------
//  req      in         req_valid/req_ready  spmv_req_type (load/begin/term)
//  rsp      out        rsp_valid/rsp_ready  spmv_rsp_type (row, y, clipped)
//
//  Cycles: one word accepted per clock while req_ready is high. A finished
//    row's closing word passes the stage 1 and stage 2 registers and is then
//    written into the result queue, which raises rsp_valid: x store read,
//    32x32 multiply, then 64-bit add and clamp into the running sum.
//  Reset: synchronous, clears the pipeline, the row state and the result
//    queue; x store contents are not cleared and must be loaded first.
//  Stalls: results wait in a four-word queue; req_ready drops only in reset
//    or when the queue plus the words still in the pipeline would fill it.
//
// Load words write the x store at their column; a term reads the entry
// when it is accepted, so a load followed at once by a term on the same
// column sees the new value without forwarding. Columns at or beyond
// X_DEPTH are ignored on load and read as zero on a term.
// The running sum, row number and clip flag sit in the last stage, so each
// term's accumulate sees the previous word's result directly.
//
module csr_sparse_matrix_vector_multiply_unit
   import spmv_pkg::*;
#(
   parameter int X_DEPTH   = X_DEPTH_DEFAULT,
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  spmv_req_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output spmv_rsp_type rsp_word
);

   localparam int CW = $clog2(RSP_FIFO_DEPTH + 1);

   logic                 req_accept;
   logic                 push_valid;
   spmv_rsp_type         push_word;
   spmv_pipe_status_type status;
   logic [CW-1:0]        count;
   logic [CW:0]          fill;

   // every word in flight may still produce a result, so count them all
   assign fill = (CW+1)'(count) + (CW+1)'(status.s1_busy) + (CW+1)'(status.s2_busy);
   assign req_ready  = !reset && (fill < (CW+1)'(RSP_FIFO_DEPTH));
   assign req_accept = req_valid && req_ready;

   spmv_datapath #(
      .X_DEPTH   (X_DEPTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_word   (req_word),
      .push_valid (push_valid),
      .push_word  (push_word),
      .status     (status)
   );

   spmv_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .pop        (rsp_valid && rsp_ready),
      .count      (count),
      .out_valid  (rsp_valid),
      .out_word   (rsp_word)
   );

endmodule

@@ rtl/spmv_checker.sv @@
// ============================================================================
// spmv_checker
// Port-level checks on the result channel and flow control.
// ============================================================================
module spmv_checker
   import spmv_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input spmv_rsp_type rsp_word
);

   // a stalled result stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // backpressure only when results are actually queued
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req_ready low with empty result queue");

   // a result appears on an empty channel only after an accepted word has passed the pipeline and the queue
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
      else $error("result without a word taken three cycles earlier");

   // stalled payload holds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_word))
      else $error("rsp_word changed while stalled");

endmodule

bind csr_sparse_matrix_vector_multiply_unit spmv_checker u_spmv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

@@ bench/spmv_row_checker.sv @@
// ----------------------------------------------------------------------------
// spmv_row_checker
// Watches both channels of the CSR SpMV unit, keeps its own copy of the x
// store and row state, predicts each finished row and compares it in order.
// ----------------------------------------------------------------------------
module spmv_row_checker
   import spmv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  spmv_req_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  spmv_rsp_type rsp_word,
   output int unsigned  fail_count,
   output int unsigned  outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int X_ENTRIES = X_DEPTH_DEFAULT;
   localparam int FRAC      = FRAC_BITS_DEFAULT;

   logic signed [VALUE_WIDTH-1:0] x_copy [X_ENTRIES];
   logic signed [VALUE_WIDTH-1:0] acc_sum;
   logic [ROW_WIDTH-1:0]          acc_row;
   logic                          acc_clipped;
   spmv_rsp_type                  pending_rows [$];
   int unsigned                   errors;

   initial begin
      foreach (x_copy[i]) x_copy[i] = '0;
      acc_sum     = '0;
      acc_row     = '0;
      acc_clipped = 1'b0;
      errors      = 0;
   end

   // one accepted request word through the row accumulator
   task automatic apply_word(input spmv_req_type w);
      logic signed [PROD_WIDTH-1:0] x_wide;
      logic signed [PROD_WIDTH-1:0] v_wide;
      logic signed [PROD_WIDTH-1:0] product;
      logic signed [PROD_WIDTH-1:0] total;
      spmv_rsp_type                 row_out;
      case (w.op)
         OP_LOAD: begin
            if (w.column < X_ENTRIES) x_copy[w.column] = w.value;
         end
         OP_BEGIN: begin
            acc_sum     = w.value;
            acc_row     = w.row_index;
            acc_clipped = 1'b0;
            if (w.empty_row) begin
               row_out.out_row   = w.row_index;
               row_out.y_value   = w.value;
               row_out.saturated = 1'b0;
               pending_rows.push_back(row_out);
            end
         end
         OP_TERM: begin
            // sign-extend before the select so a zero fill cannot creep in
            x_wide  = (w.column < X_ENTRIES) ? PROD_WIDTH'(x_copy[w.column]) : '0;
            v_wide  = w.value;
            // arithmetic shift drops low bits: floor toward minus infinity
            product = (x_wide * v_wide) >>> FRAC;
            total   = PROD_WIDTH'(acc_sum) + product;
            if (total > SUM_MAX) begin
               total       = SUM_MAX;
               acc_clipped = 1'b1;
            end else if (total < SUM_MIN) begin
               total       = SUM_MIN;
               acc_clipped = 1'b1;
            end
            acc_sum = total[VALUE_WIDTH-1:0];
            if (w.last_entry) begin
               row_out.out_row   = acc_row;
               row_out.y_value   = acc_sum;
               row_out.saturated = acc_clipped;
               pending_rows.push_back(row_out);
            end
         end
         default: ;  // unused opcode does nothing
      endcase
   endtask

   task automatic check_row(input spmv_rsp_type got);
      spmv_rsp_type want;
      if (pending_rows.size() == 0) begin
         $display("%0t: unexpected row word, got row %h y %h sat %b",
                  $time, got.out_row, got.y_value, got.saturated);
         errors++;
      end else begin
         want = pending_rows.pop_front();
         if (got.out_row !== want.out_row) begin
            $display("%0t: out_row expected %h, got %h", $time, want.out_row, got.out_row);
            errors++;
         end
         if (got.y_value !== want.y_value) begin
            $display("%0t: y_value expected %h, got %h", $time, want.y_value, got.y_value);
            errors++;
         end
         if (got.saturated !== want.saturated) begin
            $display("%0t: saturated expected %b, got %b",
                     $time, want.saturated, got.saturated);
            errors++;
         end
      end
   endtask

   // request first, so a same-edge result could still find its expectation
   always @(posedge clock) begin
      if (reset) begin
         acc_sum     = '0;
         acc_row     = '0;
         acc_clipped = 1'b0;
         pending_rows.delete();
      end else begin
         if (req_valid && req_ready) apply_word(req_word);
         if (rsp_valid && rsp_ready) check_row(rsp_word);
      end
      fail_count  <= errors;
      outstanding <= pending_rows.size();
   end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the CSR SpMV unit: a directed pass over the corner cases, then
// random CSR rows with loads and malformed words mixed in, random stalls on
// both channels and one long result hold-off. Checking sits in the checker.
// ----------------------------------------------------------------------------
module tb
   import spmv_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLOCK_HALF    = 6;
   localparam int          RESET_CYCLES  = 3;
   localparam int          RANDOM_ITEMS  = 2000;
   localparam int          HOLD_CYCLES   = 300;   // long result hold-off
   localparam int          SETTLE_CYCLES = 20;    // pipeline is 3 deep
   localparam int          IDLE_LIMIT    = 5000;  // cycles with no word moving
   localparam logic [1:0]  OP_UNUSED     = 2'd3;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   spmv_req_type req_word;
   logic         rsp_valid;
   logic         rsp_ready;
   spmv_rsp_type rsp_word;
   int unsigned  fail_count;
   int unsigned  outstanding;

   // stimulus bookkeeping
   bit          x_loaded [X_DEPTH_DEFAULT];
   int unsigned loaded_cols [$];
   int unsigned items_sent;
   bit          sender_eager;
   int unsigned idle_cycles;

   csr_sparse_matrix_vector_multiply_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   spmv_row_checker row_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Q16.16 operands: full range saturates almost always, so many values are
   // small magnitudes within two, with full-range values and the extremes mixed in
   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 35) return $urandom;
      if (r < 80) return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      case ($urandom_range(0, 4))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return 32'h0001_0000;
      endcase
   endfunction

   // terms only read x entries that were loaded
   function automatic logic [COLUMN_WIDTH-1:0] pick_column();
      return COLUMN_WIDTH'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
   endfunction

   function automatic spmv_req_type make_word(
      input logic [1:0]              op,
      input logic [COLUMN_WIDTH-1:0] column,
      input logic [ROW_WIDTH-1:0]    row,
      input logic [VALUE_WIDTH-1:0]  value,
      input logic                    last,
      input logic                    empty
   );
      spmv_req_type w;
      w.op         = op;
      w.column     = column;
      w.row_index  = row;
      w.value      = value;
      w.last_entry = last;
      w.empty_row  = empty;
      return w;
   endfunction

   // valid is only lowered when a gap follows, so a held valid never sees
   // two nonblocking writes in one step
   task automatic send_word(input spmv_req_type w);
      int unsigned gap;
      if (items_sent % 100 == 0) sender_eager = ($urandom_range(0, 2) == 0);
      gap = sender_eager ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (w.op != OP_UNUSED) items_sent++;
   endtask

   task automatic load_x(input logic [COLUMN_WIDTH-1:0] col, input logic [VALUE_WIDTH-1:0] val);
      send_word(make_word(OP_LOAD, col, ROW_WIDTH'($urandom), val,
                          1'($urandom), 1'($urandom)));
      if (!x_loaded[col]) begin
         x_loaded[col] = 1'b1;
         loaded_cols.push_back(32'(col));
      end
   endtask

   task automatic begin_row(input logic [ROW_WIDTH-1:0] row, input logic [VALUE_WIDTH-1:0] seed,
                            input logic empty);
      send_word(make_word(OP_BEGIN, COLUMN_WIDTH'($urandom), row, seed, 1'($urandom), empty));
   endtask

   task automatic term(input logic [COLUMN_WIDTH-1:0] col, input logic [VALUE_WIDTH-1:0] val,
                       input logic last);
      send_word(make_word(OP_TERM, col, ROW_WIDTH'($urandom), val, last, 1'($urandom)));
   endtask

   // well-formed row: begin, then up to max_terms terms, last one flagged
   task automatic send_row(input int unsigned max_terms);
      int unsigned n;
      n = $urandom_range(0, max_terms);
      begin_row(ROW_WIDTH'($urandom_range(0, 16'hFFFF)), pick_value(), n == 0);
      for (int unsigned k = 0; k < n; k++) term(pick_column(), pick_value(), k == n - 1);
   endtask

   // hold the sender until every predicted row word has come back
   task automatic drain_wait();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Result side: stretches of random stalls, every fourth one from the second on always-ready.
   // The fourth stretch is one long hold-off while the sender keeps going,
   // so the result queue fills and req_ready must drop.
   initial begin : rsp_side
      int unsigned stretch;
      int unsigned gap;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      stretch = 0;
      forever begin
         if (stretch == 3) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (stretch % 4 == 1) begin
            rsp_ready <= 1'b1;
            repeat (64) @(posedge clock);
         end else begin
            repeat (24) begin
               gap = pick_gap();
               if (gap > 0) begin
                  rsp_ready <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               rsp_ready <= 1'b1;
               @(posedge clock);
            end
         end
         stretch++;
      end
   end

   // watchdog: too long with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned target;
      int unsigned r;
      bit          paused;

      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_word     <= '0;
      items_sent   = 0;
      sender_eager = 1'b1;
      idle_cycles  = 0;
      paused       = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // x: one, both extremes, minus one lsb, alternating column bits
      load_x(12'h000, 32'h0001_0000);
      load_x(12'hFFF, 32'h7FFF_FFFF);
      load_x(12'h001, 32'h8000_0000);
      load_x(12'h002, 32'hFFFF_FFFF);
      load_x(12'hAAA, 32'h0002_8000);
      load_x(12'h555, 32'hFFFE_0000);
      // term straight out of reset: no begin yet, sums into zero for row 0
      term(12'h000, 32'h0003_0000, 1'b1);
      // empty rows emit their seed at once
      begin_row(16'hFFFF, 32'h8000_0000, 1'b1);
      begin_row(16'h0000, 32'h7FFF_FFFF, 1'b1);
      // clip high, then a small negative product keeps the flag
      begin_row(16'h1234, 32'h7FFF_0000, 1'b0);
      term(12'hFFF, 32'h7FFF_FFFF, 1'b0);
      term(12'h002, 32'h0001_0000, 1'b1);
      // orphan term after the row closed: same row number, flag still set
      term(12'h000, 32'hFFFF_0000, 1'b1);
      // clip low, then swing back past the top
      begin_row(16'h0F0F, 32'h8000_0000, 1'b0);
      term(12'h001, 32'h0001_0000, 1'b0);
      term(12'h555, 32'h8000_0000, 1'b1);
      // open row dropped by a new begin; negative product floors (-2.5 -> -3)
      begin_row(16'h5555, 32'h0000_0000, 1'b0);
      term(12'hAAA, 32'h0001_8000, 1'b0);
      begin_row(16'hAAAA, 32'h0000_1000, 1'b0);
      term(12'hAAA, 32'hFFFF_FFFF, 1'b1);
      // unused opcode, all other bits set
      send_word(make_word(OP_UNUSED, '1, '1, '1, 1'b1, 1'b1));
      // load mid-row, term on that column right behind it
      begin_row(16'h0007, 32'h0000_0000, 1'b0);
      load_x(12'h003, 32'h0000_0003);
      term(12'h003, 32'h0001_0000, 1'b1);

      // ---- random ----
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if (!paused && items_sent >= target - RANDOM_ITEMS / 2) begin
            drain_wait();
            paused = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 66) begin
            send_row(6);
         end else if (r < 69) begin
            send_row(24);
         end else if (r < 80) begin
            load_x(COLUMN_WIDTH'($urandom_range(0, X_DEPTH_DEFAULT - 1)), pick_value());
         end else if (r < 87) begin
            // abandoned row: terms without a closing flag
            begin_row(ROW_WIDTH'($urandom_range(0, 16'hFFFF)), pick_value(), 1'b0);
            repeat ($urandom_range(1, 3)) term(pick_column(), pick_value(), 1'b0);
         end else if (r < 94) begin
            term(pick_column(), pick_value(), 1'($urandom_range(0, 1)));
         end else begin
            send_word(make_word(OP_UNUSED, COLUMN_WIDTH'($urandom), ROW_WIDTH'($urandom),
                                $urandom, 1'($urandom), 1'($urandom)));
         end
      end

      drain_wait();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/spmv_pkg.sv
rtl/spmv_datapath.sv
rtl/spmv_rsp_fifo.sv
rtl/csr_sparse_matrix_vector_multiply_unit.sv
rtl/spmv_checker.sv
bench/spmv_row_checker.sv
bench/tb.sv
